// ===== rtl/le3_pkg.sv =====
// Shared types, constants and the entropy term table of the 3x3 local entropy filter.
package le3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int LINE_AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;
    localparam int ROW_W      = HEIGHT_W + 1;
    localparam int ENT_W      = 16;
    localparam int TERM_W     = 13;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam int WIN_N      = 9;
    localparam int CNT_W      = 4;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] pixel;
    } t_in;

    typedef struct packed {
        logic [ENT_W-1:0] entropy;
        logic             last;
    } t_out;

    // window position r*3+c, row 0 is the oldest line, column 0 the oldest pixel
    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edge;

    // -(1/9)*log2(n/9) in Q2.14, rounded to nearest
    function automatic logic [TERM_W-1:0] term_q14(input logic [CNT_W-1:0] n);
        logic [TERM_W-1:0] t;
        case (n)
            4'd1:    t = 13'd5771;
            4'd2:    t = 13'd3950;
            4'd3:    t = 13'd2885;
            4'd4:    t = 13'd2130;
            4'd5:    t = 13'd1544;
            4'd6:    t = 13'd1065;
            4'd7:    t = 13'd660;
            4'd8:    t = 13'd309;
            default: t = 13'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/local_entropy_3x3.sv =====
// Top level of the streaming 3x3 local entropy filter.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+-----------------------------
//  input   | in        | i_in_valid / o_in_ready    | i_in_data  {cmd, pixel}
//  output  | out       | o_out_valid / i_out_ready  | o_out_data {entropy, last}
//  config  | in        | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One input word is taken per clock while o_in_ready is high. A result passes the
// line read, the window shift and the term lookup, each registered, and lands in an
// eight-entry output queue; ready falls only when the queue plus the results in flight
// would fill it. The line memory holds two rows in one 16-bit word per column,
// read and rewritten once per word, with a forward path for back-to-back words on
// one column. Reset is synchronous, active low, and clears counters, valid bits and
// queue pointers, and sets the width and height registers to 2048 and 1; the line memory
// needs no clearing, as stale contents only reach masked window positions.
module local_entropy_3x3 (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  le3_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output le3_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_we,
    input  logic [le3_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [le3_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration
    logic [le3_pkg::WIDTH_W-1:0]   r_width;
    logic [le3_pkg::HEIGHT_W-1:0]  r_height;
    logic [le3_pkg::LINE_AW-1:0]   w_m1;
    logic [le3_pkg::HEIGHT_W-1:0]  h_m1;

    // position counters
    logic [le3_pkg::LINE_AW-1:0]   r_in_col;
    logic [le3_pkg::ROW_W-1:0]     r_in_row;
    logic [le3_pkg::LINE_AW-1:0]   r_out_col;
    logic [le3_pkg::HEIGHT_W-1:0]  r_out_row;

    logic                          acc;
    logic                          res;
    logic                          last;
    logic                          past_frame;
    logic [le3_pkg::PIX_W-1:0]     v;

    // stage A: word registered, line read in progress
    logic                          r_a_valid;
    logic                          r_a_res;
    logic                          r_a_last;
    le3_pkg::t_edge                r_a_edge;
    logic [le3_pkg::PIX_W-1:0]     r_a_v;
    logic [le3_pkg::LINE_AW-1:0]   r_a_col;

    // line memory: upper byte the older row, lower byte the newer
    logic [2*le3_pkg::PIX_W-1:0]   line_mem [le3_pkg::MAX_WIDTH];
    logic [2*le3_pkg::PIX_W-1:0]   r_mem_q;
    logic                          r_fwd;
    logic [2*le3_pkg::PIX_W-1:0]   r_fwd_data;
    logic [2*le3_pkg::PIX_W-1:0]   col_data;
    logic [le3_pkg::PIX_W-1:0]     top;
    logic [le3_pkg::PIX_W-1:0]     mid;

    // stage B: shifted window
    le3_pkg::t_win                 r_win;
    logic                          r_b_res;
    logic                          r_b_last;
    le3_pkg::t_edge                r_b_edge;

    // entropy result
    logic                          ent_valid;
    logic                          ent_last;
    logic [le3_pkg::ENT_W-1:0]     ent_sum;

    // output queue
    le3_pkg::t_out                 r_fifo [le3_pkg::FIFO_DEPTH];
    logic [le3_pkg::FIFO_AW-1:0]   r_wp;
    logic [le3_pkg::FIFO_AW-1:0]   r_rp;
    logic [le3_pkg::FIFO_CW-1:0]   r_cnt;
    logic                          pop;
    logic [le3_pkg::FIFO_CW:0]     pending;

    // effective frame size, less one: zero width or height counts as one,
    // width above the line length clamps to it
    always_comb begin
        if (r_width == '0) begin
            w_m1 = '0;
        end else if (32'(r_width) > le3_pkg::MAX_WIDTH) begin
            w_m1 = le3_pkg::LINE_AW'(le3_pkg::MAX_WIDTH - 1);
        end else begin
            w_m1 = le3_pkg::LINE_AW'(r_width - le3_pkg::WIDTH_W'(1));
        end
        h_m1 = (r_height == '0) ? '0 : r_height - le3_pkg::HEIGHT_W'(1);
    end

    assign acc        = i_in_valid && o_in_ready;
    assign past_frame = r_in_row > le3_pkg::ROW_W'(h_m1);
    // no result until the word one row and one pixel behind the centre arrives
    assign res        = !((r_in_row == '0) ||
                          (r_in_row == le3_pkg::ROW_W'(1) && r_in_col == '0));
    assign last       = (r_out_row == h_m1) && (r_out_col == w_m1);
    // drain words and words past the frame's end count as zero pixels
    assign v          = (i_in_data.cmd == le3_pkg::CMD_DRAIN || past_frame) ?
                        '0 : i_in_data.pixel;

    // configuration and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= le3_pkg::WIDTH_W'(2048);
            r_height  <= le3_pkg::HEIGHT_W'(1);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                le3_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[le3_pkg::WIDTH_W-1:0];
                le3_pkg::CFG_HEIGHT: r_height <= i_cfg_data[le3_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
            // restart the frame
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (acc) begin
            if (res && last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (r_in_col == w_m1) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + le3_pkg::ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + le3_pkg::LINE_AW'(1);
                end
                if (res) begin
                    if (r_out_col == w_m1) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + le3_pkg::HEIGHT_W'(1);
                    end else begin
                        r_out_col <= r_out_col + le3_pkg::LINE_AW'(1);
                    end
                end
            end
        end
    end

    // stage A registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_res         <= res;
            r_a_last        <= last;
            r_a_edge.top    <= (r_out_row == '0);
            r_a_edge.bottom <= (r_out_row == h_m1);
            r_a_edge.left   <= (r_out_col == '0);
            r_a_edge.right  <= (r_out_col == w_m1);
            r_a_v           <= v;
            r_a_col         <= r_in_col;
        end
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_a_valid <= acc;
            // the word in stage A rewrites the column being read: forward it
            r_fwd     <= acc && r_a_valid && (r_a_col == r_in_col);
        end
    end

    assign col_data = r_fwd ? r_fwd_data : r_mem_q;
    assign top      = col_data[2*le3_pkg::PIX_W-1:le3_pkg::PIX_W];
    assign mid      = col_data[le3_pkg::PIX_W-1:0];

    // line memory: read on accept, write back from stage A
    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            line_mem[r_a_col] <= {mid, r_a_v};
        end
        if (acc) begin
            r_mem_q <= line_mem[r_in_col];
        end
        r_fwd_data <= {mid, r_a_v};
    end

    // stage B: shift the window one column on every word
    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= top;
            r_win[5] <= mid;
            r_win[8] <= r_a_v;
        end
        r_b_last <= r_a_last;
        r_b_edge <= r_a_edge;
        if (!i_rst_n) begin
            r_b_res <= 1'b0;
        end else begin
            r_b_res <= r_a_valid && r_a_res;
        end
    end

    le3_entropy u_entropy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_res),
        .i_last  (r_b_last),
        .i_win   (r_win),
        .i_edge  (r_b_edge),
        .o_valid (ent_valid),
        .o_last  (ent_last),
        .o_sum   (ent_sum)
    );

    // output queue
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_fifo[r_rp];

    always_ff @(posedge i_clk) begin
        if (ent_valid) begin
            r_fifo[r_wp].entropy <= ent_sum;
            r_fifo[r_wp].last    <= ent_last;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (ent_valid) begin
                r_wp <= r_wp + le3_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + le3_pkg::FIFO_AW'(1);
            end
            if (ent_valid && !pop) begin
                r_cnt <= r_cnt + le3_pkg::FIFO_CW'(1);
            end else if (pop && !ent_valid) begin
                r_cnt <= r_cnt - le3_pkg::FIFO_CW'(1);
            end
        end
    end

    // hold input while queued plus in-flight results would fill the queue
    assign pending    = {1'b0, r_cnt}
                      + (le3_pkg::FIFO_CW+1)'(r_a_valid && r_a_res)
                      + (le3_pkg::FIFO_CW+1)'(r_b_res)
                      + (le3_pkg::FIFO_CW+1)'(ent_valid);
    assign o_in_ready = pending < (le3_pkg::FIFO_CW+1)'(le3_pkg::FIFO_DEPTH);

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent_valid |-> (r_cnt < le3_pkg::FIFO_CW'(le3_pkg::FIFO_DEPTH)))
        else $error("result pushed into a full output queue");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= le3_pkg::FIFO_CW'(le3_pkg::FIFO_DEPTH))
        else $error("output queue count beyond its depth");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_in_col == '0 && r_in_row == '0 &&
                      r_out_col == '0 && r_out_row == '0))
        else $error("frame not restarted after a register write");

    a_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_cfg_we && r_in_row == '0) |=> !r_a_res)
        else $error("result raised during the first row of a frame");

    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> $past(r_a_valid))
        else $error("line forward without a word in stage A");

endmodule

// ===== rtl/le3_entropy.sv =====
// Window masking, equal-value counting, term lookup and term sum.
module le3_entropy (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_last,
    input  le3_pkg::t_win               i_win,
    input  le3_pkg::t_edge              i_edge,
    output logic                        o_valid,
    output logic                        o_last,
    output logic [le3_pkg::ENT_W-1:0]   o_sum
);

    logic [le3_pkg::WIN_N-1:0][le3_pkg::PIX_W-1:0]  vals;
    logic [le3_pkg::WIN_N-1:0][le3_pkg::CNT_W-1:0]  cnt;
    logic [le3_pkg::WIN_N-1:0][le3_pkg::TERM_W-1:0] n_terms;
    logic [le3_pkg::WIN_N-1:0][le3_pkg::TERM_W-1:0] r_terms;
    logic                                           r_valid;
    logic                                           r_last;

    // force positions outside the frame to zero
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if ((r == 0 && i_edge.top) || (r == 2 && i_edge.bottom) ||
                    (c == 0 && i_edge.left) || (c == 2 && i_edge.right)) begin
                    vals[r*3+c] = '0;
                end else begin
                    vals[r*3+c] = i_win[r*3+c];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < le3_pkg::WIN_N; i++) begin
            cnt[i] = '0;
            for (int j = 0; j < le3_pkg::WIN_N; j++) begin
                cnt[i] = cnt[i] + le3_pkg::CNT_W'(vals[i] == vals[j]);
            end
            n_terms[i] = le3_pkg::term_q14(cnt[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_terms <= n_terms;
        r_last  <= i_last;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_comb begin
        o_sum = '0;
        for (int i = 0; i < le3_pkg::WIN_N; i++) begin
            o_sum = o_sum + le3_pkg::ENT_W'(r_terms[i]);
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the 3x3 local entropy filter: random streams with a built-in predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling: every word could meet the longest sender gap and the
    // longest receiver stall, and that total is taken several times over.
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    // Words still pass through the pipeline registers once taken; allow a margin on top.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_WORDS = 1500;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    le3_pkg::t_in                   i_in_data = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    le3_pkg::t_out                  o_out_data;
    logic                           i_cfg_we = 1'b0;
    logic [le3_pkg::CFG_IDX_W-1:0]  i_cfg_idx = le3_pkg::CFG_WIDTH;
    logic [le3_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    local_entropy_3x3 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the registers, the two line rows,
    // the 3x3 window and the input position within the frame.
    // ------------------------------------------------------------------
    logic [le3_pkg::WIDTH_W-1:0]  width_reg = 12'd2048;
    logic [le3_pkg::HEIGHT_W-1:0] height_reg = 16'd1;
    // [0..] newest row, [MAX_WIDTH..] older
    bit [le3_pkg::PIX_W-1:0]      row_pixels [2*le3_pkg::MAX_WIDTH];
    bit [le3_pkg::PIX_W-1:0]      win_px [3][3];     // [row][col], row 0 oldest, col 0 oldest
    int unsigned                  frame_pos = 0;

    le3_pkg::t_out       entropy_expected [$];
    le3_pkg::t_in        pixel_pending [$];

    int unsigned words_queued = 0;
    int unsigned words_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          in_taken = 1'b0;

    // Q2.14 entropy contribution of one window position whose value occurs n times
    function automatic int unsigned q14_term(input int unsigned n);
        case (n)
            1: return 5771;
            2: return 3950;
            3: return 2885;
            4: return 2130;
            5: return 1544;
            6: return 1065;
            7: return 660;
            8: return 309;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned active_width();
        if (width_reg == 0) return 1;
        if (width_reg > le3_pkg::MAX_WIDTH) return le3_pkg::MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    // Any register write restarts the frame.
    task automatic apply_register(input logic [le3_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [le3_pkg::CFG_DATA_W-1:0] data);
        if (idx == le3_pkg::CFG_WIDTH)
            width_reg = data[le3_pkg::WIDTH_W-1:0];
        else
            height_reg = data[le3_pkg::HEIGHT_W-1:0];
        frame_pos = 0;
    endtask

    // Advance the window by one accepted word and work out the entropy of the
    // pixel W+1 positions back, if there is one.
    task automatic entropy_step(input le3_pkg::t_in word, output bit produced,
                                output le3_pkg::t_out res);
        int unsigned w, h, total, p, col, k, rk, ck, sum, n;
        bit [le3_pkg::PIX_W-1:0] v, top, mid;
        bit [le3_pkg::PIX_W-1:0] vals [9];
        bit outside;
        int r, c, i, j;
        w = active_width();
        h = active_height();
        total = w * h;
        p = frame_pos;
        col = p % w;
        v = word.pixel;
        // drain words and anything past the frame's last pixel act as zero
        if (word.cmd == le3_pkg::CMD_DRAIN || p >= total) v = '0;

        top = row_pixels[le3_pkg::MAX_WIDTH + col];
        mid = row_pixels[col];
        row_pixels[le3_pkg::MAX_WIDTH + col] = mid;
        row_pixels[col] = v;
        for (r = 0; r < 3; r++) begin
            win_px[r][0] = win_px[r][1];
            win_px[r][1] = win_px[r][2];
        end
        win_px[0][2] = top;
        win_px[1][2] = mid;
        win_px[2][2] = v;
        frame_pos = p + 1;

        produced = 1'b0;
        res = '0;
        if (p >= w + 1) begin
            k = p - w - 1;
            rk = k / w;
            ck = k % w;
            // force positions beyond the frame edges to zero
            for (r = 0; r < 3; r++) begin
                for (c = 0; c < 3; c++) begin
                    outside = (r == 0 && rk == 0) || (r == 2 && rk == h - 1) ||
                              (c == 0 && ck == 0) || (c == 2 && ck == w - 1);
                    vals[r*3 + c] = outside ? 8'd0 : win_px[r][c];
                end
            end
            sum = 0;
            for (i = 0; i < 9; i++) begin
                n = 0;
                for (j = 0; j < 9; j++)
                    if (vals[j] == vals[i]) n++;
                sum += q14_term(n);
            end
            res.entropy = 16'(sum);
            res.last = (k + 1 >= total);
            if (res.last) frame_pos = 0;
            produced = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: check results against the oldest expectation, then fold in
    // register writes and accepted input words. Sample at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        bit produced;
        le3_pkg::t_out res;
        le3_pkg::t_out want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_checked++;
                if (entropy_expected.size() == 0) begin
                    $error("result word with nothing expected: entropy %0d last %0b",
                           o_out_data.entropy, o_out_data.last);
                    error_count++;
                end else begin
                    want = entropy_expected.pop_front();
                    if (o_out_data.entropy !== want.entropy) begin
                        $error("entropy: expected %0d, actual %0d",
                               want.entropy, o_out_data.entropy);
                        error_count++;
                    end
                    if (o_out_data.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, o_out_data.last);
                        error_count++;
                    end
                end
            end
            if (i_cfg_we) apply_register(i_cfg_idx, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                entropy_step(i_in_data, produced, res);
                if (produced) entropy_expected.insert(entropy_expected.size(), res);
                words_accepted++;
                in_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: present pending words in bursts with random gaps. Hold valid
    // and the word steady until taken; change inputs on the falling edge.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(negedge i_clk) begin : driver
        logic next_valid;
        le3_pkg::t_in next_word;
        next_valid = i_in_valid;
        next_word = i_in_data;
        if (in_taken) next_valid = 1'b0;
        if (!next_valid && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pixel_pending.size() > 0) begin
                next_word = pixel_pending.pop_front();
                next_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // a third of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        i_in_valid <= next_valid;
        i_in_data <= next_word;
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a stall mode drawn anew at random, from never stalling to
    // mostly stalled.
    // ------------------------------------------------------------------
    int unsigned rx_cycle = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_run = 0;
    bit          rx_level = 1'b1;

    always @(negedge i_clk) begin : receiver
        logic next_ready;
        rx_cycle++;
        if (rx_cycle % 400 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: next_ready = 1'b1;
            1: next_ready = ($urandom_range(0, 3) != 0);
            2: begin
                // long runs of ready and of stall
                if (rx_run == 0) begin
                    rx_level = ~rx_level;
                    rx_run = $urandom_range(1, 24);
                end else begin
                    rx_run--;
                end
                next_ready = rx_level;
            end
            default: next_ready = ($urandom_range(0, 3) == 0);
        endcase
        i_out_ready <= next_ready;
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results still expected",
                     cycle_count, entropy_expected.size());
            $display("local_entropy_3x3 test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    bit [le3_pkg::PIX_W-1:0] palette [9];

    function automatic logic [le3_pkg::PIX_W-1:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_word(input logic cmd, input logic [le3_pkg::PIX_W-1:0] px);
        le3_pkg::t_in word;
        word.cmd = cmd;
        word.pixel = px;
        pixel_pending.insert(pixel_pending.size(), word);
        words_queued++;
    endtask

    // Write one register on the falling edge; the enable is high for a single cycle.
    task automatic write_reg(input logic [le3_pkg::CFG_IDX_W-1:0] idx,
                             input logic [le3_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every word is taken and every result has arrived, then let
    // the pipeline empty of words that cause no result.
    task automatic wait_quiet();
        do begin
            @(posedge i_clk);
            #1;
        end while (words_accepted != words_queued || entropy_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        #1;
    endtask

    // Queue one frame and its padding. A cut frame stops anywhere short of
    // its end, leaving the block mid-frame for the next register write.
    task automatic send_frame(input int unsigned w, input int unsigned h, input bit cut_short);
        int unsigned n_words, stop_at, i, pal_n;
        bit full_random;
        pal_n = $urandom_range(1, 9);
        // few distinct values give repeats inside the window, hence varied counts
        for (i = 0; i < 9; i++)
            palette[i] = ($urandom_range(0, 5) == 0) ?
                         ($urandom_range(0, 1) ? 8'hFF : 8'h00) : any_byte();
        full_random = ($urandom_range(0, 3) == 0);
        n_words = w * h + w + 1;
        stop_at = cut_short ? $urandom_range(1, n_words - 1) : n_words;
        for (i = 0; i < stop_at; i++) begin
            if (i < w * h) begin
                if ($urandom_range(0, 19) == 0)
                    queue_word(le3_pkg::CMD_DRAIN, any_byte());
                else
                    queue_word(le3_pkg::CMD_PIXEL, full_random ? any_byte() :
                               palette[$urandom_range(0, pal_n - 1)]);
            end else begin
                // padding: drain words or pixel words past the frame's end
                queue_word($urandom_range(0, 1) ? le3_pkg::CMD_DRAIN : le3_pkg::CMD_PIXEL,
                           any_byte());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned random_start, w, h, frames, f, i, r;
        bit force_cfg, wrote, cut;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 1x1 frame from zero width and zero height; the trailing pixel word is padding
        write_reg(le3_pkg::CFG_WIDTH, 16'h0000);
        write_reg(le3_pkg::CFG_HEIGHT, 16'h0000);
        queue_word(le3_pkg::CMD_PIXEL, 8'hFF);
        queue_word(le3_pkg::CMD_DRAIN, 8'hA5);
        queue_word(le3_pkg::CMD_PIXEL, 8'h3C);
        wait_quiet();

        // 3x3 frame of nine distinct values: the centre window reaches the top
        // entropy. Bits above the 12-bit width register are dropped.
        write_reg(le3_pkg::CFG_WIDTH, 16'hF003);
        write_reg(le3_pkg::CFG_HEIGHT, 16'd3);
        queue_word(le3_pkg::CMD_PIXEL, 8'h00);
        queue_word(le3_pkg::CMD_PIXEL, 8'h80);
        queue_word(le3_pkg::CMD_PIXEL, 8'h7F);
        queue_word(le3_pkg::CMD_PIXEL, 8'hFF);
        queue_word(le3_pkg::CMD_PIXEL, 8'h01);
        queue_word(le3_pkg::CMD_PIXEL, 8'h55);
        queue_word(le3_pkg::CMD_PIXEL, 8'hAA);
        queue_word(le3_pkg::CMD_PIXEL, 8'hFE);
        queue_word(le3_pkg::CMD_PIXEL, 8'h2A);
        queue_word(le3_pkg::CMD_DRAIN, 8'hFF);
        queue_word(le3_pkg::CMD_PIXEL, 8'h11);
        queue_word(le3_pkg::CMD_DRAIN, 8'h00);
        queue_word(le3_pkg::CMD_PIXEL, 8'hC3);
        wait_quiet();

        // drain word inside a 2x1 frame counts as a zero pixel
        write_reg(le3_pkg::CFG_WIDTH, 16'd2);
        write_reg(le3_pkg::CFG_HEIGHT, 16'd1);
        queue_word(le3_pkg::CMD_DRAIN, 8'hFF);
        queue_word(le3_pkg::CMD_PIXEL, 8'h00);
        queue_word(le3_pkg::CMD_DRAIN, 8'h5A);
        queue_word(le3_pkg::CMD_PIXEL, 8'hFF);
        queue_word(le3_pkg::CMD_DRAIN, 8'h81);
        wait_quiet();

        // tallest setting: run part of a frame, the next write restarts it
        write_reg(le3_pkg::CFG_WIDTH, 16'd2);
        write_reg(le3_pkg::CFG_HEIGHT, 16'hFFFF);
        for (i = 0; i < 60; i++) queue_word(le3_pkg::CMD_PIXEL, any_byte());
        wait_quiet();

        // random phases: new or kept settings, then one to three frames each
        force_cfg = 1'b1;
        random_start = words_queued;
        while (words_queued - random_start < RANDOM_WORDS) begin
            wrote = 1'b0;
            if (force_cfg || $urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, 19);
                w = (r < 14) ? $urandom_range(1, 8) :
                    (r < 19) ? $urandom_range(9, 40) : $urandom_range(41, 160);
                write_reg(le3_pkg::CFG_WIDTH, {4'($urandom_range(0, 15)), 12'(w)});
                wrote = 1'b1;
            end
            if (force_cfg || $urandom_range(0, 3) != 0) begin
                h = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
                write_reg(le3_pkg::CFG_HEIGHT, 16'(h));
                wrote = 1'b1;
            end
            if (!wrote) begin
                // keep the settings; frames continue from the last clean end
            end
            force_cfg = 1'b0;
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
                cut = (f == frames - 1) && ($urandom_range(0, 9) == 0);
                send_frame(active_width(), active_height(), cut);
                if (cut) force_cfg = 1'b1;
            end
            wait_quiet();
        end

        $display("Covered %0d words and %0d checked results over %0d register writes,",
                 words_accepted, results_checked, reg_writes);
        $display("widths 1 to 160 and zero, heights 1 to 16, zero and a cut 65535-row frame");
        if (error_count == 0)
            $display("local_entropy_3x3 test passed");
        else
            $display("local_entropy_3x3 test failed");
        $finish;
    end

endmodule
